[rtl/lfps_pkg.sv]
package lfps_pkg;

    localparam int SENSOR_COUNT = 12;

    localparam logic [31:0] PERIOD_MS       = 32'd20;
    localparam logic [31:0] LOST_TIMEOUT_MS = 32'd700;
    localparam logic [3:0]  CROWD_COUNT     = 4'd6;
    localparam logic [6:0]  ERR_LIMIT       = 7'd110;
    localparam logic [6:0]  INT_LIMIT       = 7'd100;
    localparam logic [6:0]  INT_BAND        = 7'd80;
    localparam logic [6:0]  GAIN_DIV        = 7'd100;
    localparam logic [5:0]  HALF_MASK       = 6'h3F;

    localparam int DIVD_W = 17;
    localparam int DIVS_W = 7;

    // rounded-up reciprocals for the constant divides; with 24 fraction bits
    // the quotient is exact for every dividend below 2^17
    localparam int          RCP_SHIFT     = 24;
    localparam logic [17:0] RCP_GAIN_DIV  =
        18'(((1 << RCP_SHIFT) + int'(GAIN_DIV) - 1) / int'(GAIN_DIV));
    localparam logic [17:0] RCP_ERR_LIMIT =
        18'(((1 << RCP_SHIFT) + int'(ERR_LIMIT) - 1) / int'(ERR_LIMIT));

    typedef enum logic [3:0] {
        ST_IDLE, ST_CENT, ST_PID, ST_MI, ST_MD, ST_DTURN, ST_MS, ST_DSPD, ST_OUT
    } t_state;

    typedef enum logic [1:0] {ACT_SKIP = 2'd0, ACT_DRIVE = 2'd1, ACT_STOP = 2'd2} t_action;
    typedef enum logic [1:0] {LS_TRACK = 2'd0, LS_CROSS = 2'd1, LS_LOST = 2'd2} t_line;

    typedef enum logic [2:0] {
        REG_ENABLE, REG_GAIN_P, REG_GAIN_I, REG_GAIN_D,
        REG_BASE_SPEED, REG_MIN_SPEED, REG_LOST_SPEED, REG_TURN_LIMIT
    } t_cfg_reg;

    typedef struct packed {
        logic              start;
        logic [DIVD_W-1:0] dividend;
        logic [DIVS_W-1:0] divisor;
    } t_div_req;

    function automatic logic [2:0] pop6(input logic [5:0] v);
        logic [2:0] n;
        n = '0;
        for (int i = 0; i < 6; i++) begin
            n = n + {2'b0, v[i]};
        end
        return n;
    endfunction

    function automatic logic [3:0] pop12(input logic [SENSOR_COUNT-1:0] v);
        logic [3:0] n;
        n = '0;
        for (int i = 0; i < SENSOR_COUNT; i++) begin
            n = n + {3'b0, v[i]};
        end
        return n;
    endfunction

    // sum of sensor positions, odd weights from -11 to +11
    function automatic logic signed [6:0] centroid_sum(input logic [SENSOR_COUNT-1:0] v);
        logic signed [6:0] s;
        int w;
        s = '0;
        for (int i = 0; i < SENSOR_COUNT; i++) begin
            w = 2 * i - (SENSOR_COUNT - 1);
            if (v[i]) begin
                s = s + 7'(w);
            end
        end
        return s;
    endfunction

endpackage

[rtl/line_follow_pid_steer.sv]
// Channel  | Direction | Handshake              | Payload
// input    | in        | i_valid / o_stall      | i_sensor_bits, i_now_ms
// result   | out       | o_valid / i_stall      | o_action .. o_line_state
// config   | in        | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// Skipped and lost samples go from acceptance straight to the output step.
// A tracked sample runs the 17-step serial centroid divide, then seven sequencer
// steps (PID, MI, MD, DTURN, MS, DSPD, OUT) that use the shared multiplier and
// reciprocal multiplier; a crowded sample needs no centroid divide.
// One sample is in work at a time; the result register frees the input side.
// Reset is synchronous, active low; config registers return to defaults.
// A stalled result holds; the sequencer waits in its output step until free.
module line_follow_pid_steer
    import lfps_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [SENSOR_COUNT-1:0] i_sensor_bits,
    input  logic [31:0]             i_now_ms,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic [1:0]              o_action,
    output logic [5:0]              o_forward_speed,
    output logic signed [6:0]       o_turn,
    output logic signed [7:0]       o_error_tenths,
    output logic [3:0]              o_active_count,
    output logic [1:0]              o_line_state,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [2:0]              i_cfg_index,
    input  logic [7:0]              i_cfg_data
);

    t_state r_state, n_state;

    logic       r_enable;
    logic [7:0] r_gain_p, r_gain_i, r_gain_d;
    logic [5:0] r_base_speed, r_min_speed, r_lost_speed, r_turn_limit;

    logic              r_run_next, r_lost_timing;
    logic [31:0]       r_last_run, r_lost_since;
    logic signed [7:0] r_last_error, r_prior_error, r_integral;
    logic signed [8:0] r_slope;
    logic signed [6:0] r_last_turn;

    logic              r_sign;
    logic signed [7:0] r_err;
    logic signed [17:0] r_acc;
    logic [16:0]       r_mag;

    logic [1:0]        r_res_action, r_res_line;
    logic [5:0]        r_res_speed;
    logic signed [6:0] r_res_turn;
    logic signed [7:0] r_res_error;
    logic [3:0]        r_res_count;

    logic              r_out_valid;
    logic [1:0]        r_o_action, r_o_line;
    logic [5:0]        r_o_speed;
    logic signed [6:0] r_o_turn;
    logic signed [7:0] r_o_error;
    logic [3:0]        r_o_count;

    logic              w_accept, w_out_free, w_skip, w_crowd_l, w_crowd_r;
    logic [3:0]        w_count;
    logic [2:0]        w_left, w_right;
    logic signed [6:0] w_sum;
    logic signed [9:0] w_sum10;
    logic [8:0]        w_sum_mag;
    logic [31:0]       w_elapsed;
    logic signed [6:0] w_lim, w_search_turn;
    logic [6:0]        w_err_mag;

    logic signed [9:0]  w_mul_x, w_mul_y;
    logic signed [19:0] w_prod;
    logic signed [17:0] w_acc_sum;

    logic [17:0]       w_rcp_k;
    logic [34:0]       w_rcp_prod;
    logic [10:0]       w_rcp_q;

    logic signed [8:0]  w_int_add, w_int_clamp, w_int_half;
    logic signed [10:0] w_dlt, w_dlt_half;

    logic [DIVD_W-1:0] w_quo;
    logic              w_div_done;
    t_div_req          w_div_req;
    logic [8:0]        w_cent_q;
    logic signed [7:0] w_cent_err;
    logic [5:0]        w_turn_mag;
    logic signed [6:0] w_turn;
    logic signed [7:0] w_spd_q, w_spd;

    lfps_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (w_div_req),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    // decode the incoming sample
    always_comb begin
        w_accept   = i_valid && !o_stall;
        w_out_free = !r_out_valid || !i_stall;
        w_skip     = !r_enable || (!r_run_next && ((i_now_ms - r_last_run) < PERIOD_MS));
        w_count    = pop12(i_sensor_bits);
        w_left     = pop6(i_sensor_bits[5:0] & HALF_MASK);
        w_right    = pop6(i_sensor_bits[11:6] & HALF_MASK);
        w_crowd_l  = (w_count >= CROWD_COUNT) && ({1'b0, w_left} > ({1'b0, w_right} + 4'd1));
        w_crowd_r  = (w_count >= CROWD_COUNT) && ({1'b0, w_right} > ({1'b0, w_left} + 4'd1));
        w_sum      = centroid_sum(i_sensor_bits);
        w_sum10    = {{3{w_sum[6]}}, w_sum} * 10'sd10;
        w_sum_mag  = w_sum10[9] ? 9'(-w_sum10) : w_sum10[8:0];
        w_elapsed  = r_lost_timing ? (i_now_ms - r_lost_since) : 32'd0;
        w_lim      = {1'b0, r_turn_limit};
        if (r_last_turn != 0) begin
            w_search_turn = (r_last_turn > 0) ? w_lim : -w_lim;
        end else begin
            w_search_turn = (r_last_error >= 0) ? -w_lim : w_lim;
        end
    end

    // select operands of the shared multiplier
    always_comb begin
        w_err_mag = r_err[7] ? 7'(-r_err) : r_err[6:0];
        case (r_state)
            ST_MI: begin
                w_mul_x = {2'b0, r_gain_i};
                w_mul_y = {{2{r_integral[7]}}, r_integral};
            end
            ST_MD: begin
                w_mul_x = {2'b0, r_gain_d};
                w_mul_y = {r_slope[8], r_slope};
            end
            ST_MS: begin
                w_mul_x = 10'({1'b0, r_base_speed}) - 10'({1'b0, r_min_speed});
                w_mul_y = {3'b0, w_err_mag};
            end
            default: begin
                w_mul_x = {2'b0, r_gain_p};
                w_mul_y = {{2{r_err[7]}}, r_err};
            end
        endcase
        w_prod    = w_mul_x * w_mul_y;
        w_acc_sum = r_acc + w_prod[17:0];
    end

    // divide the held magnitude by a constant through its reciprocal
    always_comb begin
        w_rcp_k    = (r_state == ST_DSPD) ? RCP_ERR_LIMIT : RCP_GAIN_DIV;
        w_rcp_prod = 35'(r_mag) * 35'(w_rcp_k);
        w_rcp_q    = w_rcp_prod[34:RCP_SHIFT];
    end

    // integral and filtered slope updates
    always_comb begin
        w_int_add = {r_integral[7], r_integral} + {r_err[7], r_err};
        if (w_int_add > $signed({2'b0, INT_LIMIT})) begin
            w_int_clamp = $signed({2'b0, INT_LIMIT});
        end else if (w_int_add < -$signed({2'b0, INT_LIMIT})) begin
            w_int_clamp = -$signed({2'b0, INT_LIMIT});
        end else begin
            w_int_clamp = w_int_add;
        end
        w_int_half = ({r_integral[7], r_integral} + {8'b0, r_integral[7]}) >>> 1;
        w_dlt      = 11'(r_err) - 11'(r_prior_error) - 11'(r_slope);
        w_dlt_half = (w_dlt + {10'b0, w_dlt[10]}) >>> 1;
    end

    // shape quotients into error, turn and speed
    always_comb begin
        w_cent_q   = (w_quo > 17'(ERR_LIMIT)) ? {2'b0, ERR_LIMIT} : w_quo[8:0];
        w_cent_err = r_sign ? -$signed(w_cent_q[7:0]) : $signed(w_cent_q[7:0]);
        w_turn_mag = (w_rcp_q > 11'(r_turn_limit)) ? r_turn_limit : w_rcp_q[5:0];
        w_turn     = r_sign ? $signed({1'b0, w_turn_mag}) : -$signed({1'b0, w_turn_mag});
        w_spd_q    = r_sign ? -$signed({2'b0, w_rcp_q[5:0]}) : $signed({2'b0, w_rcp_q[5:0]});
        w_spd      = $signed({2'b0, r_base_speed}) - w_spd_q;
        if (w_spd < $signed({2'b0, r_min_speed})) begin
            w_spd = $signed({2'b0, r_min_speed});
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (w_skip || w_count == '0) begin
                        n_state = ST_OUT;
                    end else if (w_crowd_l || w_crowd_r) begin
                        n_state = ST_PID;
                    end else begin
                        n_state = ST_CENT;
                    end
                end
            end
            ST_CENT:  if (w_div_done) n_state = ST_PID;
            ST_PID:   n_state = ST_MI;
            ST_MI:    n_state = ST_MD;
            ST_MD:    n_state = ST_DTURN;
            ST_DTURN: n_state = ST_MS;
            ST_MS:    n_state = ST_DSPD;
            ST_DSPD:  n_state = ST_OUT;
            ST_OUT:   if (w_out_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // sequencer outputs: divider launch and handshakes
    always_comb begin
        w_div_req = '0;
        unique case (r_state)
            ST_IDLE: begin
                w_div_req.start    = w_accept && !w_skip && (w_count != '0)
                                     && !w_crowd_l && !w_crowd_r;
                w_div_req.dividend = 17'(w_sum_mag);
                w_div_req.divisor  = {3'b0, w_count};
            end
            default: w_div_req = '0;
        endcase
        o_stall     = (r_state != ST_IDLE);
        o_cfg_ready = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        r_state <= !i_rst_n ? ST_IDLE : n_state;
    end

    // config registers and controller state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable      <= 1'b0;
            r_gain_p      <= 8'd15;
            r_gain_i      <= 8'd0;
            r_gain_d      <= 8'd20;
            r_base_speed  <= 6'd10;
            r_min_speed   <= 6'd6;
            r_lost_speed  <= 6'd3;
            r_turn_limit  <= 6'd20;
            r_last_run    <= '0;
            r_run_next    <= 1'b0;
            r_lost_since  <= '0;
            r_lost_timing <= 1'b0;
            r_last_error  <= '0;
            r_prior_error <= '0;
            r_integral    <= '0;
            r_slope       <= '0;
            r_last_turn   <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (t_cfg_reg'(i_cfg_index))
                    REG_ENABLE: begin
                        r_enable      <= i_cfg_data[0];
                        r_run_next    <= i_cfg_data[0];
                        r_lost_timing <= 1'b0;
                        r_lost_since  <= '0;
                        r_last_error  <= '0;
                        r_prior_error <= '0;
                        r_integral    <= '0;
                        r_slope       <= '0;
                        r_last_turn   <= '0;
                    end
                    REG_GAIN_P:     r_gain_p     <= i_cfg_data;
                    REG_GAIN_I:     r_gain_i     <= i_cfg_data;
                    REG_GAIN_D:     r_gain_d     <= i_cfg_data;
                    REG_BASE_SPEED: r_base_speed <= i_cfg_data[5:0];
                    REG_MIN_SPEED:  r_min_speed  <= i_cfg_data[5:0];
                    REG_LOST_SPEED: r_lost_speed <= i_cfg_data[5:0];
                    REG_TURN_LIMIT: r_turn_limit <= i_cfg_data[5:0];
                    default: ;
                endcase
            end
            // take the sample time and track the lost timer
            if (r_state == ST_IDLE && w_accept && !w_skip) begin
                r_last_run <= i_now_ms;
                r_run_next <= 1'b0;
                if (w_count == '0) begin
                    if (!r_lost_timing) begin
                        r_lost_timing <= 1'b1;
                        r_lost_since  <= i_now_ms;
                    end
                end else begin
                    r_lost_timing <= 1'b0;
                    r_lost_since  <= '0;
                end
            end
            // advance the PID state
            if (r_state == ST_PID) begin
                r_integral    <= ((r_err[7] ? 7'(-r_err) : r_err[6:0]) < INT_BAND)
                                 ? w_int_clamp[7:0] : w_int_half[7:0];
                r_slope       <= r_slope + w_dlt_half[8:0];
                r_prior_error <= r_err;
                r_last_error  <= r_err;
            end
            if (r_state == ST_DTURN) begin
                r_last_turn <= w_turn;
            end
        end
    end

    // datapath and result registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                r_sign <= w_sum[6];
                if (w_crowd_l) begin
                    r_err <= -$signed({1'b0, ERR_LIMIT});
                end else begin
                    r_err <= $signed({1'b0, ERR_LIMIT});
                end
                if (w_skip) begin
                    r_res_action <= ACT_SKIP;
                    r_res_error  <= '0;
                    r_res_count  <= '0;
                    r_res_line   <= LS_TRACK;
                    r_res_speed  <= '0;
                    r_res_turn   <= '0;
                end else if (w_count == '0) begin
                    r_res_count <= w_count;
                    r_res_line  <= LS_LOST;
                    r_res_error <= r_last_error;
                    if (w_elapsed > LOST_TIMEOUT_MS) begin
                        r_res_action <= ACT_STOP;
                        r_res_speed  <= '0;
                        r_res_turn   <= '0;
                    end else begin
                        r_res_action <= ACT_DRIVE;
                        r_res_speed  <= r_lost_speed;
                        r_res_turn   <= w_search_turn;
                    end
                end else begin
                    r_res_action <= ACT_DRIVE;
                    r_res_count  <= w_count;
                    r_res_line   <= (w_count >= CROWD_COUNT) ? LS_CROSS : LS_TRACK;
                    r_res_speed  <= '0;
                    r_res_turn   <= '0;
                end
            end
            ST_CENT: if (w_div_done) r_err <= w_cent_err;
            ST_PID: begin
                r_acc       <= w_prod[17:0];
                r_res_error <= r_err;
            end
            ST_MI: r_acc <= w_acc_sum;
            ST_MD: begin
                r_sign <= w_acc_sum[17];
                r_mag  <= w_acc_sum[17] ? 17'(-w_acc_sum) : w_acc_sum[16:0];
            end
            ST_DTURN: r_res_turn <= w_turn;
            ST_MS: begin
                r_sign <= w_prod[19];
                r_mag  <= w_prod[19] ? 17'(-w_prod) : w_prod[16:0];
            end
            ST_DSPD: r_res_speed <= w_spd[5:0];
            default: ;
        endcase
    end

    // output register: load when free, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_OUT && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_OUT && w_out_free) begin
            r_o_action <= r_res_action;
            r_o_speed  <= r_res_speed;
            r_o_turn   <= r_res_turn;
            r_o_error  <= r_res_error;
            r_o_count  <= r_res_count;
            r_o_line   <= r_res_line;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_action        = r_o_action;
    assign o_forward_speed = r_o_speed;
    assign o_turn          = r_o_turn;
    assign o_error_tenths  = r_o_error;
    assign o_active_count  = r_o_count;
    assign o_line_state    = r_o_line;

`ifndef SYNTHESIS
    a_skip_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_o_action == ACT_SKIP |-> r_o_turn == 0 && r_o_speed == 0)
        else $error("skipped sample carries a command");
    a_lost_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_o_line == LS_LOST |-> r_o_count == 0)
        else $error("lost line with lit sensors");
    a_int_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_integral <= 8'sd100 && r_integral >= -8'sd100)
        else $error("integral out of range");
    a_err_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_o_error <= 8'sd110 && r_o_error >= -8'sd110)
        else $error("error out of range");
`endif

endmodule

[rtl/lfps_div.sv]
module lfps_div
    import lfps_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_div_req          i_req,
    output logic              o_done,
    output logic [DIVD_W-1:0] o_quotient
);

    logic              r_busy;
    logic              r_done;
    logic [4:0]        r_cnt;
    logic [DIVS_W-1:0] r_rem;
    logic [DIVS_W-1:0] r_div;
    logic [DIVD_W-1:0] r_quo;
    logic [DIVS_W:0]   w_rem_sh;
    logic              w_ge;
    logic [DIVS_W:0]   w_rem_sub;

    // one restoring step: shift in next dividend bit, try subtract
    always_comb begin
        w_rem_sh  = {r_rem, r_quo[DIVD_W-1]};
        w_ge      = w_rem_sh >= {1'b0, r_div};
        w_rem_sub = w_rem_sh - {1'b0, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= !i_req.start && r_busy && (r_cnt == '0);
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'(DIVD_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // payload path
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_div <= i_req.divisor;
            r_quo <= i_req.dividend;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_rem_sub[DIVS_W-1:0] : w_rem_sh[DIVS_W-1:0];
            r_quo <= {r_quo[DIVD_W-2:0], w_ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

[sim/line_follow_pid_steer_test.sv]
module line_follow_pid_steer_test;
    import lfps_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;

    typedef struct {
        logic [1:0] action;
        logic [5:0] speed;
        logic [6:0] turn;
        logic [7:0] err;
        logic [3:0] count;
        logic [1:0] lstate;
    } t_steer;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_valid;
    logic                    o_stall;
    logic [SENSOR_COUNT-1:0] i_sensor_bits;
    logic [31:0]             i_now_ms;
    logic                    o_valid;
    logic                    i_stall;
    logic [1:0]              o_action;
    logic [5:0]              o_forward_speed;
    logic signed [6:0]       o_turn;
    logic signed [7:0]       o_error_tenths;
    logic [3:0]              o_active_count;
    logic [1:0]              o_line_state;
    logic                    i_cfg_valid;
    logic                    o_cfg_ready;
    logic [2:0]              i_cfg_index;
    logic [7:0]              i_cfg_data;

    line_follow_pid_steer uut (.*);

    // predictor copy of registers and controller state
    int unsigned cf_enable, cf_gp, cf_gi, cf_gd, cf_base, cf_min, cf_lost, cf_tlim;
    logic [31:0] last_run_time, lost_since;
    bit          run_next, lost_timing;
    int          last_error, prior_error, integral_sum, smoothed_slope, last_turn;

    t_steer      steer_queue[$];
    int          mismatches;
    int          cycles;
    logic [31:0] clock_ms;
    bit          stall_quiet;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // bound the run
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic int random_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // result side back-pressure, with quiet stretches
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if ($urandom_range(0, 199) == 0) stall_quiet = ~stall_quiet;
            if (stall_quiet) i_stall <= 1'b0;
            else i_stall <= (random_gap() > 0);
        end
    end

    function automatic void clear_controller();
        last_error = 0;
        prior_error = 0;
        integral_sum = 0;
        smoothed_slope = 0;
        last_turn = 0;
    endfunction

    function automatic void apply_register(t_cfg_reg idx, logic [7:0] val);
        case (idx)
            REG_ENABLE: begin
                cf_enable = val[0];
                run_next = val[0];
                lost_timing = 1'b0;
                lost_since = '0;
                clear_controller();
            end
            REG_GAIN_P:     cf_gp = val;
            REG_GAIN_I:     cf_gi = val;
            REG_GAIN_D:     cf_gd = val;
            REG_BASE_SPEED: cf_base = val[5:0];
            REG_MIN_SPEED:  cf_min = val[5:0];
            REG_LOST_SPEED: cf_lost = val[5:0];
            REG_TURN_LIMIT: cf_tlim = val[5:0];
            default: ;
        endcase
    endfunction

    function automatic int line_position(logic [11:0] bits, int count);
        int left, right, sum;
        left = $countones(bits[5:0]);
        right = $countones(bits[11:6]);
        sum = 0;
        if (count >= 6 && left > right + 1) return -110;
        if (count >= 6 && right > left + 1) return 110;
        for (int i = 0; i < 12; i++) begin
            if (bits[i]) sum += -11 + 2 * i;
        end
        sum = (sum * 10) / count;
        if (sum > 110) sum = 110;
        else if (sum < -110) sum = -110;
        return sum;
    endfunction

    function automatic int steer_from_error(int e);
        int mag, lim, u;
        mag = e < 0 ? -e : e;
        lim = cf_tlim;
        if (mag < 80) begin
            integral_sum += e;
            if (integral_sum > 100) integral_sum = 100;
            else if (integral_sum < -100) integral_sum = -100;
        end else begin
            integral_sum = integral_sum / 2;
        end
        smoothed_slope += ((e - prior_error) - smoothed_slope) / 2;
        prior_error = e;
        u = int'(cf_gp) * e + int'(cf_gi) * integral_sum + int'(cf_gd) * smoothed_slope;
        u = -u / 100;
        last_error = e;
        if (u > lim) u = lim;
        else if (u < -lim) u = -lim;
        last_turn = u;
        return u;
    endfunction

    function automatic t_steer predict_steer(logic [11:0] bits, logic [31:0] now);
        t_steer r;
        int count, e, turn, speed, mag, lim;
        r = '{default: '0};
        if (cf_enable == 0 || (!run_next && (now - last_run_time) < PERIOD_MS)) begin
            r.action = ACT_SKIP;
            return r;
        end
        last_run_time = now;
        run_next = 1'b0;
        count = $countones(bits);
        turn = 0;
        speed = 0;
        if (count == 0) begin
            r.lstate = LS_LOST;
            e = last_error;
            if (!lost_timing) begin
                lost_timing = 1'b1;
                lost_since = now;
            end
            if ((now - lost_since) > LOST_TIMEOUT_MS) begin
                r.action = ACT_STOP;
            end else begin
                lim = cf_tlim;
                r.action = ACT_DRIVE;
                speed = cf_lost;
                if (last_turn != 0) turn = last_turn > 0 ? lim : -lim;
                else turn = last_error >= 0 ? -lim : lim;
            end
        end else begin
            lost_timing = 1'b0;
            lost_since = '0;
            e = line_position(bits, count);
            turn = steer_from_error(e);
            mag = e < 0 ? -e : e;
            speed = int'(cf_base) - ((int'(cf_base) - int'(cf_min)) * mag) / 110;
            if (speed < int'(cf_min)) speed = cf_min;
            r.action = ACT_DRIVE;
            r.lstate = count >= 6 ? LS_CROSS : LS_TRACK;
        end
        r.speed = speed[5:0];
        r.turn = turn[6:0];
        r.err = e[7:0];
        r.count = count[3:0];
        return r;
    endfunction

    // compare each delivered result with the oldest expectation
    always @(posedge i_clk) begin
        t_steer want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (steer_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result action=%0d", o_action);
            end else begin
                want = steer_queue.pop_front();
                if (want.action !== o_action || want.speed !== o_forward_speed ||
                    want.turn !== o_turn || want.err !== o_error_tenths ||
                    want.count !== o_active_count || want.lstate !== o_line_state) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch exp act=%0d spd=%0d turn=%0d err=%0d cnt=%0d ls=%0d",
                                 want.action, want.speed, $signed(want.turn),
                                 $signed(want.err), want.count, want.lstate,
                                 " got act=%0d spd=%0d turn=%0d err=%0d cnt=%0d ls=%0d",
                                 o_action, o_forward_speed, o_turn, o_error_tenths,
                                 o_active_count, o_line_state);
                end
            end
        end
    end

    // send one sample; leaves valid high so a following sample can go back to back
    task automatic send_sample(logic [11:0] bits, logic [31:0] now);
        int gap;
        gap = random_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_sensor_bits <= bits;
        i_now_ms <= now;
        forever begin
            @(posedge i_clk);
            if (!o_stall) break;
        end
        steer_queue.push_back(predict_steer(bits, now));
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (steer_queue.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_register(t_cfg_reg idx, logic [7:0] val);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        forever begin
            @(posedge i_clk);
            if (o_cfg_ready) break;
        end
        apply_register(idx, val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // advance the clock by a normal period and send
    task automatic step_sample(logic [11:0] bits);
        clock_ms += 20 + $urandom_range(0, 10);
        send_sample(bits, clock_ms);
    endtask

    task automatic test_disabled();
        send_sample(12'h0F0, 32'd100);
        send_sample(12'hFFF, 32'hFFFF_FFFF);
    endtask

    task automatic test_patterns();
        write_register(REG_ENABLE, 8'd1);
        clock_ms = 32'd5;
        send_sample(12'h060, clock_ms);
        send_sample(12'h001, clock_ms + 5);   // inside the period: skipped
        step_sample(12'h001);
        step_sample(12'h800);
        step_sample(12'hFFF);
        step_sample(12'h03F);
        step_sample(12'hFC0);
        step_sample(12'h0FF);
        step_sample(12'hFF0);
        step_sample(12'h555);
        step_sample(12'hAAA);
        step_sample(12'h00C);
        step_sample(12'h300);
        step_sample(12'h7E0);
    endtask

    task automatic test_lost_line();
        step_sample(12'h003);
        step_sample(12'h000);
        step_sample(12'h000);
        clock_ms += 650;
        send_sample(12'h000, clock_ms);
        clock_ms += 80;
        send_sample(12'h000, clock_ms);      // past the lost timeout
        step_sample(12'h000);
        step_sample(12'h180);                // found again
        write_register(REG_ENABLE, 8'd1);
        send_sample(12'h000, clock_ms + 1);  // first after enable, no history
    endtask

    task automatic test_time_wrap();
        clock_ms = 32'hFFFF_FFF0;
        write_register(REG_ENABLE, 8'd1);
        send_sample(12'h030, clock_ms);
        send_sample(12'h030, 32'h0000_0002); // 18 ms across the wrap: skipped
        send_sample(12'h030, 32'h0000_0004);
        clock_ms = 32'h0000_0004;
        step_sample(12'h000);
        send_sample(12'h000, 32'h8000_0000);
    endtask

    task automatic test_min_above_base();
        write_register(REG_BASE_SPEED, 8'd5);
        write_register(REG_MIN_SPEED, 8'd40);
        write_register(REG_ENABLE, 8'd1);
        clock_ms = $urandom;
        send_sample(12'h001, clock_ms);
        step_sample(12'h060);
        write_register(REG_ENABLE, 8'd0);
        step_sample(12'h060);
    endtask

    // one setting of the registers, then a run of mostly track-like samples
    task automatic run_phase(int n, logic [7:0] gp, logic [7:0] gi, logic [7:0] gd,
                             logic [7:0] bs, logic [7:0] ms, logic [7:0] ls,
                             logic [7:0] tl);
        int pos, r;
        logic [11:0] bits;
        write_register(REG_GAIN_P, gp);
        write_register(REG_GAIN_I, gi);
        write_register(REG_GAIN_D, gd);
        write_register(REG_BASE_SPEED, bs);
        write_register(REG_MIN_SPEED, ms);
        write_register(REG_LOST_SPEED, ls);
        write_register(REG_TURN_LIMIT, tl);
        write_register(REG_ENABLE, 8'd1);
        clock_ms = $urandom;
        pos = $urandom_range(0, 11);
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(0, 99);
            if (r < 60) begin
                // drifting line one to three sensors wide
                pos += $urandom_range(0, 2) - 1;
                if (pos < 0) pos = 0;
                if (pos > 11) pos = 11;
                bits = ((12'h007 >> $urandom_range(0, 2)) << pos);
            end else if (r < 72) begin
                bits = '0;
            end else if (r < 80) begin
                bits = 12'hFFF >> $urandom_range(0, 11);
                if ($urandom_range(0, 1)) bits = {<<{bits}};
            end else begin
                bits = 12'($urandom);
            end
            r = $urandom_range(0, 99);
            if (r < 80) clock_ms += $urandom_range(20, 40);
            else if (r < 92) clock_ms += $urandom_range(0, 19);
            else clock_ms += $urandom_range(100, 900);
            send_sample(bits, clock_ms);
            if (k == n / 2 && $urandom_range(0, 1)) wait_drained();
        end
    endtask

    task automatic test_random();
        run_phase(150, 8'd15, 8'd0, 8'd20, 8'd10, 8'd6, 8'd3, 8'd20);
        run_phase(150, 8'd255, 8'd255, 8'd255, 8'd63, 8'd0, 8'd63, 8'd63);
        run_phase(150, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
        run_phase(150, 8'd40, 8'd30, 8'd120, 8'd50, 8'd20, 8'd10, 8'd30);
        for (int p = 0; p < 3; p++) begin
            run_phase(150, 8'($urandom), 8'($urandom), 8'($urandom),
                      8'($urandom_range(0, 63)), 8'($urandom_range(0, 63)),
                      8'($urandom_range(0, 63)), 8'($urandom_range(0, 63)));
        end
    endtask

    initial begin
        cycles = 0;
        mismatches = 0;
        stall_quiet = 1'b0;
        clock_ms = '0;
        cf_enable = 0; cf_gp = 15; cf_gi = 0; cf_gd = 20;
        cf_base = 10; cf_min = 6; cf_lost = 3; cf_tlim = 20;
        last_run_time = '0; lost_since = '0; run_next = 1'b0; lost_timing = 1'b0;
        clear_controller();
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_sensor_bits = '0;
        i_now_ms = '0;
        i_stall = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = REG_ENABLE;
        i_cfg_data = '0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_disabled();
        test_patterns();
        test_lost_line();
        test_time_wrap();
        test_min_above_base();
        test_random();

        wait_drained();
        repeat (80) @(negedge i_clk);
        if (mismatches == 0 && steer_queue.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
